// File: sv/iterative_pose_from_points_top_defines.svh
// Assertion macros shared by the pose solver RTL
`ifndef ITERATIVE_POSE_FROM_POINTS_TOP_DEFINES_SVH
`define ITERATIVE_POSE_FROM_POINTS_TOP_DEFINES_SVH

// same-cycle implication
`define IPFP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IPFP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ipfp_pkg.sv
// Shared constants, types and fixed-point helpers of the pose solver
package ipfp_pkg;

   localparam int MAX_POINTS     = 64;
   localparam int MAX_ITERATIONS = 64;
   localparam int FRAC_BITS      = 16;

   localparam int PT_AW  = $clog2(MAX_POINTS);
   localparam int CNT_W  = PT_AW + 1;
   localparam int PASS_W = $clog2(MAX_ITERATIONS) + 1;
   localparam int DIV_W  = 32 + FRAC_BITS;
   localparam int FSQ_W  = 62 - FRAC_BITS;
   localparam int PT_W   = 320;
   localparam int WIMG_W = 64;

   localparam logic [31:0] WORD_MAX    = 32'h7fff_ffff;
   localparam logic [30:0] FOCAL_RESET = 31'(1 << FRAC_BITS);
   localparam logic [63:0] CONV_LIM    = 64'((64'd1 << (2 * FRAC_BITS)) - 64'd1);

   typedef logic signed [31:0] word_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   // operand order of the six cross-product terms, r1 in even, r2 in odd slots
   localparam logic [2:0] CROSS_A [6] = '{3'd2, 3'd4, 3'd4, 3'd0, 3'd0, 3'd2};
   localparam logic [2:0] CROSS_B [6] = '{3'd5, 3'd3, 3'd1, 3'd5, 3'd3, 3'd1};
   localparam logic [2:0] NORM_IDX [8] = '{3'd0, 3'd2, 3'd4, 3'd1, 3'd3, 3'd5, 3'd0, 3'd0};

   function automatic word_type sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // floor shift of a product
   function automatic logic signed [63:0] asr(input logic signed [65:0] v);
      logic signed [65:0] t;
      t = v >>> FRAC_BITS;
      return t[63:0];
   endfunction

   function automatic logic signed [32:0] sx33(input logic [31:0] w);
      return {w[31], w};
   endfunction

   function automatic logic signed [63:0] sx64(input logic [31:0] w);
      return {{32{w[31]}}, w};
   endfunction

endpackage

// File: sv/ipfp_ram.sv
// Single-port-write, registered-read RAM
module ipfp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/ipfp_sqrt.sv
// Floored square root of a 64-bit value, two radicand bits per cycle
module ipfp_sqrt import ipfp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [63:0]     radicand,
   output logic [31:0]     root,
   output unit_status_type status
);

   logic [63:0] rad_ff;
   logic [34:0] rem_ff;
   logic [31:0] root_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [34:0] rem_in;
   logic [34:0] trial;

   assign rem_in = {rem_ff[32:0], rad_ff[63:62]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rad_ff <= {rad_ff[61:0], 2'b00};
            if (rem_in >= trial) begin
               rem_ff  <= rem_in - trial;
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= rem_in;
               root_ff <= {root_ff[30:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign root   = root_ff;
   assign status = '{busy: busy_ff, done: done_ff};

endmodule

// File: sv/ipfp_div.sv
// Unsigned restoring divider, one quotient bit per cycle
module ipfp_div import ipfp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [31:0]      divisor,
   output logic [DIV_W-1:0] quotient,
   output unit_status_type  status
);

   localparam int DCNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0]  quo_ff;
   logic [31:0]       rem_ff;
   logic [31:0]       den_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [32:0]       rem_in;

   assign rem_in = {rem_ff, quo_ff[DIV_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            den_ff  <= divisor;
         end else if (busy_ff) begin
            if (rem_in >= {1'b0, den_ff}) begin
               rem_ff <= 32'(rem_in - {1'b0, den_ff});
               quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_in[31:0];
               quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = quo_ff;
   assign status   = '{busy: busy_ff, done: done_ff};

endmodule

// File: sv/iterative_pose_from_points_top.sv
// Top level of the iterative pose solver: point stores, sequencer and shared arithmetic
//
// Point items are taken one per cycle while the block is loading; the first MAX_POINTS
// are written to the point RAM and the weighted-image RAM, later ones are dropped. The
// item flagged last_point starts the solve and the input stays stalled until the four
// result items (rotation rows 0..2, then the translation with the scale) have all been
// taken. One pass runs the projection of every point, the norms, three 32-step square
// roots and a 48-step divide for the scale, then the reweighting of every point (a
// 48-step divide for the weight); the shared 33x33 multiplier and the RAM read port
// pace these steps. A run takes between two passes and the iteration cap.
`include "iterative_pose_from_points_top_defines.svh"
module iterative_pose_from_points_top import ipfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_image_x,
   input  logic [31:0] req_image_y,
   input  logic [31:0] req_world_x,
   input  logic [31:0] req_world_y,
   input  logic [31:0] req_world_z,
   input  logic [31:0] req_world_w,
   input  logic [31:0] req_pinv_0,
   input  logic [31:0] req_pinv_1,
   input  logic [31:0] req_pinv_2,
   input  logic [31:0] req_pinv_3,
   input  logic        req_last_point,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_row_index,
   output logic [31:0] rsp_col_0,
   output logic [31:0] rsp_col_1,
   output logic [31:0] rsp_col_2,
   output logic        rsp_converged,
   output logic        rsp_last_result,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [2:0] CSR_FOCAL = 3'd0;

   typedef enum logic [4:0] {
      S_LOAD, S_FSQ, S_PROJ, S_SAT, S_NORM, S_SQA, S_SQB, S_AB, S_SQM, S_DIVS,
      S_SCALE, S_CROSS, S_POSE, S_WEIGHT, S_WDIV, S_WUPD, S_CHECK, S_EMIT
   } state_type;

   state_type          state_ff;
   logic [3:0]         sub_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   k_ff;
   logic [PASS_W-1:0]  pass_ff;
   logic [1:0]         row_ff;
   logic               conv_ff;
   logic [30:0]        focal_ff;
   logic [FSQ_W-1:0]   fsq_ff;
   logic signed [63:0] acc_ff [8];
   word_type           r_ff [8];
   word_type           r3_ff [3];
   word_type           pose_ff [12];
   logic [63:0]        na_ff;
   logic [63:0]        nb_ff;
   logic [31:0]        a_ff;
   logic [31:0]        b_ff;
   logic [63:0]        ab_ff;
   logic [31:0]        m_ff;
   logic [30:0]        s_ff;
   logic signed [63:0] hold_ff;
   logic signed [63:0] num_ff;
   logic               neg_ff;
   word_type           wk_ff;
   word_type           nv0_ff;
   word_type           nv1_ff;
   word_type           d0_ff;
   word_type           d1_ff;
   logic [63:0]        delta_ff;
   logic signed [65:0] prod_ff;

   logic signed [32:0] ma;
   logic signed [32:0] mb;
   logic [3:0]         jm;
   logic [3:0]         jc;

   logic               req_acc;
   logic               pt_we;
   logic               wimg_we;
   logic [PT_AW-1:0]   wimg_waddr;
   logic [WIMG_W-1:0]  wimg_wdata;
   logic [PT_W-1:0]    pt_q;
   logic [WIMG_W-1:0]  wimg_q;
   logic [PT_W-1:0]    pt_wdata;

   logic               sq_start;
   logic [63:0]        sq_in;
   logic [31:0]        sq_root;
   unit_status_type    sq_st;
   logic               dv_start;
   logic [DIV_W-1:0]   dv_num;
   logic [31:0]        dv_den;
   logic [DIV_W-1:0]   dv_q;
   unit_status_type    dv_st;

   word_type           num_s;
   logic [32:0]        mag;
   logic signed [63:0] qs;
   word_type           nv_c;
   word_type           wold;
   word_type           d_c;
   logic [63:0]        dterm;
   logic               csr_wr;
   logic [3:0]         pbase;
   logic               delta_hi;
   logic               ok_prod;
   logic               ok;
   logic [64:0]        total;

   assign jm = sub_ff - 4'd1;
   assign jc = sub_ff - 4'd2;

   // ---------------- configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr == CSR_FOCAL);
   assign prdata = (paddr == CSR_FOCAL) ? {1'b0, focal_ff} : 32'd0;

   // ---------------- point stores
   assign req_ready = (state_ff == S_LOAD);
   assign req_acc   = req_valid && req_ready;
   assign pt_we     = req_acc && (cnt_ff < CNT_W'(MAX_POINTS));
   assign pt_wdata  = {req_pinv_3, req_pinv_2, req_pinv_1, req_pinv_0,
                       req_world_w, req_world_z, req_world_y, req_world_x,
                       req_image_y, req_image_x};
   assign wimg_we    = pt_we || (state_ff == S_WUPD && sub_ff == 4'd4);
   assign wimg_waddr = pt_we ? cnt_ff[PT_AW-1:0] : k_ff[PT_AW-1:0];
   assign wimg_wdata = pt_we ? {req_image_y, req_image_x} : {nv1_ff, nv0_ff};

   ipfp_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
      .clock (clock),
      .we    (pt_we),
      .waddr (cnt_ff[PT_AW-1:0]),
      .wdata (pt_wdata),
      .raddr (k_ff[PT_AW-1:0]),
      .rdata (pt_q)
   );

   ipfp_ram #(.WIDTH(WIMG_W), .DEPTH(MAX_POINTS)) u_wimg_ram (
      .clock (clock),
      .we    (wimg_we),
      .waddr (wimg_waddr),
      .wdata (wimg_wdata),
      .raddr (k_ff[PT_AW-1:0]),
      .rdata (wimg_q)
   );

   // ---------------- iterative units
   assign sq_start = (state_ff == S_SQA || state_ff == S_SQB || state_ff == S_SQM)
                     && (sub_ff == 4'd0);
   assign sq_in    = (state_ff == S_SQA) ? na_ff : ((state_ff == S_SQB) ? nb_ff : ab_ff);

   ipfp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_in),
      .root     (sq_root),
      .status   (sq_st)
   );

   assign num_s    = sat32(num_ff);
   assign mag      = num_s[31] ? (33'd0 - {num_s[31], num_s}) : {1'b0, num_s};
   assign dv_start = (state_ff == S_DIVS && sub_ff == 4'd0 && m_ff != 32'd0)
                     || (state_ff == S_WEIGHT && sub_ff == 4'd5);
   assign dv_num   = (state_ff == S_DIVS) ? DIV_W'(64'd1 << (2 * FRAC_BITS))
                                          : {mag[31:0], {FRAC_BITS{1'b0}}};
   assign dv_den   = (state_ff == S_DIVS) ? m_ff : {1'b0, s_ff};

   ipfp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_num),
      .divisor  (dv_den),
      .quotient (dv_q),
      .status   (dv_st)
   );

   assign qs = neg_ff ? (64'sd0 - 64'(dv_q)) : 64'(dv_q);

   // reweight lane values, lane 0 in sub 1, lane 1 in sub 2
   assign nv_c  = sat32(asr(prod_ff));
   assign wold  = (sub_ff == 4'd1) ? wimg_q[31:0] : wimg_q[63:32];
   assign d_c   = sat32(sx64(wold) - sx64(nv_c));
   assign dterm = 64'(prod_ff[63:FRAC_BITS]);

   // convergence: f^2 * delta <= lim, at most one operand above 32 bits
   assign delta_hi = (delta_ff[63:32] != 32'd0);
   assign total    = {1'b0, hold_ff} + {1'b0, prod_ff[15:0], 32'd0};
   assign ok_prod  = (delta_ff <= CONV_LIM) && (64'(fsq_ff) <= CONV_LIM)
                     && !(delta_hi && (fsq_ff[FSQ_W-1:32] != '0))
                     && (prod_ff[65:16] == '0) && (total <= {1'b0, CONV_LIM});
   assign ok       = (delta_ff == 64'd0) || (fsq_ff == '0) || ok_prod;

   // ---------------- shared multiplier operands
   always_comb begin
      ma = '0;
      mb = '0;
      case (state_ff)
         S_FSQ: begin
            ma = {2'b00, focal_ff};
            mb = {2'b00, focal_ff};
         end
         S_PROJ: begin
            if (sub_ff >= 4'd1 && sub_ff <= 4'd8) begin
               ma = sx33(pt_q[32 * (6 + int'(jm[2:1])) +: 32]);
               mb = sx33(wimg_q[32 * int'(jm[0]) +: 32]);
            end
         end
         S_NORM: begin
            ma = sx33(r_ff[NORM_IDX[sub_ff[2:0]]]);
            mb = sx33(r_ff[NORM_IDX[sub_ff[2:0]]]);
         end
         S_AB: begin
            ma = {1'b0, a_ff};
            mb = {1'b0, b_ff};
         end
         S_SCALE: begin
            ma = sx33(r_ff[sub_ff[2:0]]);
            mb = {2'b00, s_ff};
         end
         S_CROSS: begin
            if (sub_ff < 4'd6) begin
               ma = sx33(r_ff[CROSS_A[sub_ff[2:0]]]);
               mb = sx33(r_ff[CROSS_B[sub_ff[2:0]]]);
            end
         end
         S_WEIGHT: begin
            if (sub_ff >= 4'd1 && sub_ff <= 4'd3) begin
               ma = sx33(pt_q[32 * (2 + int'(jm[1:0])) +: 32]);
               mb = sx33(r3_ff[jm[1:0]]);
            end
         end
         S_WUPD: begin
            case (sub_ff)
               4'd0: begin
                  ma = sx33(wk_ff);
                  mb = sx33(pt_q[31:0]);
               end
               4'd1: begin
                  ma = sx33(wk_ff);
                  mb = sx33(pt_q[63:32]);
               end
               4'd2: begin
                  ma = sx33(d0_ff);
                  mb = sx33(d0_ff);
               end
               4'd3: begin
                  ma = sx33(d1_ff);
                  mb = sx33(d1_ff);
               end
               default: begin
                  ma = '0;
                  mb = '0;
               end
            endcase
         end
         S_CHECK: begin
            if (sub_ff == 4'd0) begin
               ma = {1'b0, delta_ff[31:0]};
               mb = {1'b0, fsq_ff[31:0]};
            end else if (delta_hi) begin
               ma = {1'b0, delta_ff[63:32]};
               mb = {1'b0, fsq_ff[31:0]};
            end else begin
               ma = {1'b0, delta_ff[31:0]};
               mb = 33'(fsq_ff[FSQ_W-1:32]);
            end
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= ma * mb;
   end

   // ---------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         sub_ff   <= '0;
         cnt_ff   <= '0;
         k_ff     <= '0;
         pass_ff  <= '0;
         row_ff   <= '0;
         conv_ff  <= 1'b0;
         focal_ff <= FOCAL_RESET;
         for (int i = 0; i < 12; i++) pose_ff[i] <= '0;
      end else begin
         if (csr_wr) focal_ff <= pwdata[30:0];
         case (state_ff)
            S_LOAD: begin
               if (req_acc) begin
                  if (pt_we) cnt_ff <= cnt_ff + 1'b1;
                  if (req_last_point) begin
                     state_ff <= S_FSQ;
                     sub_ff   <= '0;
                  end
               end
            end
            S_FSQ: begin
               if (sub_ff == 4'd0) begin
                  sub_ff <= 4'd1;
               end else begin
                  fsq_ff   <= prod_ff[61:FRAC_BITS];
                  pass_ff  <= '0;
                  k_ff     <= '0;
                  sub_ff   <= '0;
                  for (int i = 0; i < 8; i++) acc_ff[i] <= '0;
                  state_ff <= S_PROJ;
               end
            end
            S_PROJ: begin
               if (cnt_ff == '0) begin
                  state_ff <= S_SAT;
               end else begin
                  if (sub_ff >= 4'd2) acc_ff[jc[2:0]] <= acc_ff[jc[2:0]] + asr(prod_ff);
                  if (sub_ff == 4'd9) begin
                     sub_ff <= '0;
                     if (k_ff + 1'b1 == cnt_ff) state_ff <= S_SAT;
                     else k_ff <= k_ff + 1'b1;
                  end else begin
                     sub_ff <= sub_ff + 4'd1;
                  end
               end
            end
            S_SAT: begin
               for (int i = 0; i < 8; i++) r_ff[i] <= sat32(acc_ff[i]);
               na_ff    <= '0;
               nb_ff    <= '0;
               sub_ff   <= '0;
               state_ff <= S_NORM;
            end
            S_NORM: begin
               if (sub_ff >= 4'd1) begin
                  if (sub_ff <= 4'd3) na_ff <= na_ff + prod_ff[63:0];
                  else nb_ff <= nb_ff + prod_ff[63:0];
               end
               if (sub_ff == 4'd6) begin
                  sub_ff   <= '0;
                  state_ff <= S_SQA;
               end else begin
                  sub_ff <= sub_ff + 4'd1;
               end
            end
            S_SQA: begin
               if (sub_ff == 4'd0) begin
                  sub_ff <= 4'd1;
               end else if (sq_st.done) begin
                  a_ff     <= sq_root;
                  sub_ff   <= '0;
                  state_ff <= S_SQB;
               end
            end
            S_SQB: begin
               if (sub_ff == 4'd0) begin
                  sub_ff <= 4'd1;
               end else if (sq_st.done) begin
                  b_ff     <= sq_root;
                  sub_ff   <= '0;
                  state_ff <= S_AB;
               end
            end
            S_AB: begin
               if (sub_ff == 4'd0) begin
                  sub_ff <= 4'd1;
               end else begin
                  ab_ff    <= prod_ff[63:0];
                  sub_ff   <= '0;
                  state_ff <= S_SQM;
               end
            end
            S_SQM: begin
               if (sub_ff == 4'd0) begin
                  sub_ff <= 4'd1;
               end else if (sq_st.done) begin
                  m_ff     <= sq_root;
                  sub_ff   <= '0;
                  state_ff <= S_DIVS;
               end
            end
            S_DIVS: begin
               if (sub_ff == 4'd0) begin
                  if (m_ff == 32'd0) begin
                     s_ff     <= WORD_MAX[30:0];
                     state_ff <= S_SCALE;
                  end else begin
                     sub_ff <= 4'd1;
                  end
               end else if (dv_st.done) begin
                  if (dv_q > DIV_W'(WORD_MAX)) s_ff <= WORD_MAX[30:0];
                  else if (dv_q == '0) s_ff <= 31'd1;
                  else s_ff <= dv_q[30:0];
                  sub_ff   <= '0;
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               if (sub_ff >= 4'd1) r_ff[jm[2:0]] <= sat32(asr(prod_ff));
               if (sub_ff == 4'd8) begin
                  sub_ff   <= '0;
                  state_ff <= S_CROSS;
               end else begin
                  sub_ff <= sub_ff + 4'd1;
               end
            end
            S_CROSS: begin
               if (sub_ff >= 4'd1) begin
                  if (!jm[0]) hold_ff <= asr(prod_ff);
                  else r3_ff[jm[2:1]] <= sat32(hold_ff - asr(prod_ff));
               end
               if (sub_ff == 4'd6) begin
                  sub_ff   <= '0;
                  state_ff <= S_POSE;
               end else begin
                  sub_ff <= sub_ff + 4'd1;
               end
            end
            S_POSE: begin
               for (int i = 0; i < 3; i++) begin
                  pose_ff[i]     <= r_ff[2 * i];
                  pose_ff[3 + i] <= r_ff[2 * i + 1];
                  pose_ff[6 + i] <= r3_ff[i];
               end
               pose_ff[9]  <= r_ff[6];
               pose_ff[10] <= r_ff[7];
               pose_ff[11] <= {1'b0, s_ff};
               delta_ff    <= '0;
               k_ff        <= '0;
               sub_ff      <= '0;
               state_ff    <= (cnt_ff == '0) ? S_CHECK : S_WEIGHT;
            end
            S_WEIGHT: begin
               if (sub_ff == 4'd0) num_ff <= '0;
               if (sub_ff >= 4'd2 && sub_ff <= 4'd4) num_ff <= num_ff + asr(prod_ff);
               if (sub_ff == 4'd5) begin
                  neg_ff   <= num_s[31];
                  sub_ff   <= '0;
                  state_ff <= S_WDIV;
               end else begin
                  sub_ff <= sub_ff + 4'd1;
               end
            end
            S_WDIV: begin
               if (dv_st.done) begin
                  wk_ff    <= sat32(qs + sx64(pt_q[191:160]));
                  sub_ff   <= '0;
                  state_ff <= S_WUPD;
               end
            end
            S_WUPD: begin
               case (sub_ff)
                  4'd1: begin
                     nv0_ff <= nv_c;
                     d0_ff  <= d_c;
                  end
                  4'd2: begin
                     nv1_ff <= nv_c;
                     d1_ff  <= d_c;
                  end
                  4'd3: delta_ff <= delta_ff + dterm;
                  4'd4: delta_ff <= delta_ff + dterm;
                  default: ;
               endcase
               if (sub_ff == 4'd4) begin
                  sub_ff <= '0;
                  if (k_ff + 1'b1 == cnt_ff) begin
                     state_ff <= S_CHECK;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= S_WEIGHT;
                  end
               end else begin
                  sub_ff <= sub_ff + 4'd1;
               end
            end
            S_CHECK: begin
               if (sub_ff == 4'd0) begin
                  sub_ff <= 4'd1;
               end else if (sub_ff == 4'd1) begin
                  hold_ff <= prod_ff[63:0];
                  sub_ff  <= 4'd2;
               end else begin
                  sub_ff <= '0;
                  if (pass_ff != '0 && ok) begin
                     conv_ff  <= 1'b1;
                     row_ff   <= '0;
                     state_ff <= S_EMIT;
                  end else if (pass_ff + 1'b1 >= PASS_W'(MAX_ITERATIONS)) begin
                     conv_ff  <= 1'b0;
                     row_ff   <= '0;
                     state_ff <= S_EMIT;
                  end else begin
                     pass_ff  <= pass_ff + 1'b1;
                     k_ff     <= '0;
                     for (int i = 0; i < 8; i++) acc_ff[i] <= '0;
                     state_ff <= S_PROJ;
                  end
               end
            end
            S_EMIT: begin
               if (rsp_ready) begin
                  if (row_ff == 2'd3) begin
                     row_ff   <= '0;
                     cnt_ff   <= '0;
                     state_ff <= S_LOAD;
                  end else begin
                     row_ff <= row_ff + 2'd1;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   // ---------------- result items
   assign pbase           = 4'(row_ff) * 4'd3;
   assign rsp_valid       = (state_ff == S_EMIT);
   assign rsp_row_index   = row_ff;
   assign rsp_col_0       = pose_ff[pbase];
   assign rsp_col_1       = pose_ff[pbase + 4'd1];
   assign rsp_col_2       = pose_ff[pbase + 4'd2];
   assign rsp_converged   = conv_ff;
   assign rsp_last_result = (row_ff == 2'd3);

   `IPFP_ASSERT_NOW(a_no_load_while_emit, req_ready, !rsp_valid, "input open while results pending")
   `IPFP_ASSERT_NEXT(a_load_after_last, rsp_valid && rsp_ready && rsp_last_result, req_ready, "no return to loading after the translation item")
   `IPFP_ASSERT_NOW(a_units_exclusive, sq_st.busy, !dv_st.busy, "square root and divider busy together")
   `IPFP_ASSERT_NEXT(a_row_steps, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row_index), "result row moved while stalled")

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the iterative pose solver: point runs, pose rows, focal register
module tb_top;
   import ipfp_pkg::*;

   localparam logic [2:0] FOCAL_ADDR = 3'd0;
   localparam int ONE = 1 << FRAC_BITS;
   localparam int TOP = 32'h7fff_ffff;
   localparam int BOT = 32'h8000_0000;
   localparam int N_PHASES = 5;

   typedef longint unsigned u64_type;

   typedef struct {
      int  ix, iy;
      int  w[4];
      int  p[4];
      bit  last;
      bit  zero_pose;   // result typed in: no motion, scale at max, converged
   } point_type;

   typedef struct {
      bit [1:0] row;
      int       c[3];
      bit       conv, last;
   } pose_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid, req_ready, req_last_point;
   logic [31:0] req_image_x, req_image_y, req_world_x, req_world_y, req_world_z, req_world_w;
   logic [31:0] req_pinv_0, req_pinv_1, req_pinv_2, req_pinv_3;
   logic        rsp_valid, rsp_ready, rsp_converged, rsp_last_result;
   logic [1:0]  rsp_row_index;
   logic [31:0] rsp_col_0, rsp_col_1, rsp_col_2;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;

   iterative_pose_from_points_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // solver state as the bench sees it
   int          img [MAX_POINTS][2];
   int          wimg [MAX_POINTS][2];
   int          mdl [MAX_POINTS][4];
   int          pinv [MAX_POINTS][4];
   int          npts;
   int          pose [12];
   logic [30:0] focal;

   pose_row_type pose_rows_due [$];
   point_type    dir_rows [$];
   int           errors;
   int           hold_left;
   bit           steady;

   function automatic int clip32(longint v);
      if (v > longint'(TOP)) return TOP;
      if (v < longint'(BOT)) return BOT;
      return int'(v);
   endfunction

   function automatic longint fx_mul(int a, int b);
      return (longint'(a) * longint'(b)) >>> FRAC_BITS;
   endfunction

   function automatic u64_type root64(u64_type v);
      u64_type res, bitv;
      res = 0;
      bitv = u64_type'(1) << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic bit solve_pose();
      int      r1 [4], r2 [4], r3 [3];
      int      s, wk, nv, d;
      longint  acc1, acc2, num, q;
      u64_type a, b, m, delta, fsq, qq, n1, n2;
      bit      ok;
      for (int pass = 0; pass < MAX_ITERATIONS; pass++) begin
         for (int i = 0; i < 4; i++) begin
            acc1 = 0;
            acc2 = 0;
            for (int k = 0; k < npts; k++) begin
               acc1 += fx_mul(pinv[k][i], wimg[k][0]);
               acc2 += fx_mul(pinv[k][i], wimg[k][1]);
            end
            r1[i] = clip32(acc1);
            r2[i] = clip32(acc2);
         end
         n1 = 0;
         n2 = 0;
         for (int i = 0; i < 3; i++) begin
            n1 += u64_type'(longint'(r1[i]) * r1[i]);
            n2 += u64_type'(longint'(r2[i]) * r2[i]);
         end
         a = root64(n1);
         b = root64(n2);
         m = root64(a * b);
         if (m == 0) begin
            s = TOP;
         end else begin
            qq = (u64_type'(1) << (2 * FRAC_BITS)) / m;
            s = (qq > u64_type'(TOP)) ? TOP : int'(qq);
         end
         if (s < 1) s = 1;
         for (int i = 0; i < 4; i++) begin
            r1[i] = clip32(fx_mul(r1[i], s));
            r2[i] = clip32(fx_mul(r2[i], s));
         end
         r3[0] = clip32(fx_mul(r1[1], r2[2]) - fx_mul(r1[2], r2[1]));
         r3[1] = clip32(fx_mul(r1[2], r2[0]) - fx_mul(r1[0], r2[2]));
         r3[2] = clip32(fx_mul(r1[0], r2[1]) - fx_mul(r1[1], r2[0]));
         for (int i = 0; i < 3; i++) begin
            pose[i] = r1[i];
            pose[3 + i] = r2[i];
            pose[6 + i] = r3[i];
         end
         pose[9] = r1[3];
         pose[10] = r2[3];
         pose[11] = s;
         delta = 0;
         for (int k = 0; k < npts; k++) begin
            num = 0;
            for (int i = 0; i < 3; i++) num += fx_mul(mdl[k][i], r3[i]);
            q = longint'(clip32(num)) * longint'(ONE) / longint'(s);
            wk = clip32(q + mdl[k][3]);
            for (int c = 0; c < 2; c++) begin
               nv = clip32(fx_mul(wk, img[k][c]));
               d = clip32(longint'(wimg[k][c]) - nv);
               wimg[k][c] = nv;
               delta += u64_type'(longint'(d) * d) >> FRAC_BITS;
            end
         end
         fsq = (u64_type'(focal) * u64_type'(focal)) >> FRAC_BITS;
         ok = (delta == 0) || (fsq == 0) || (fsq <= CONV_LIM / delta);
         if (pass > 0 && ok) return 1'b1;
      end
      return 1'b0;
   endfunction

   // store one accepted point and, on the last one, queue the four pose rows
   function automatic void take_point(point_type p);
      pose_row_type e;
      bit           conv;
      if (npts < MAX_POINTS) begin
         img[npts] = '{p.ix, p.iy};
         wimg[npts] = '{p.ix, p.iy};
         mdl[npts] = p.w;
         pinv[npts] = p.p;
         npts++;
      end
      if (!p.last) return;
      conv = solve_pose();
      npts = 0;
      for (int r = 0; r < 4; r++) begin
         e.row = r;
         e.conv = conv;
         e.last = (r == 3);
         for (int j = 0; j < 3; j++) e.c[j] = pose[r * 3 + j];
         if (p.zero_pose) begin
            e.c = '{0, 0, (r == 3) ? TOP : 0};
            e.conv = 1'b1;
         end
         pose_rows_due.push_back(e);
      end
   endfunction

   function automatic point_type mk(int ix, int iy, int wx, int wy, int wz, int ww,
                                    int p0, int p1, int p2, int p3, bit last, bit zp = 0);
      point_type p;
      p.ix = ix;
      p.iy = iy;
      p.w = '{wx, wy, wz, ww};
      p.p = '{p0, p1, p2, p3};
      p.last = last;
      p.zero_pose = zp;
      return p;
   endfunction

   // noise covers every bit; otherwise a plausible scene with w = 1.0
   function automatic point_type rand_point(bit noise, bit last);
      point_type p;
      if (noise) begin
         return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, last);
      end
      p = mk(int'($urandom_range(0, 2 * ONE)) - ONE, int'($urandom_range(0, 2 * ONE)) - ONE,
             int'($urandom_range(0, 4 * ONE)) - 2 * ONE,
             int'($urandom_range(0, 4 * ONE)) - 2 * ONE,
             int'($urandom_range(0, 4 * ONE)) - 2 * ONE, ONE,
             int'($urandom_range(0, 2 * ONE)) - ONE, int'($urandom_range(0, 2 * ONE)) - ONE,
             int'($urandom_range(0, 2 * ONE)) - ONE, int'($urandom_range(0, ONE / 4)), last);
      return p;
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   task automatic report_mismatch(string what, int want, int got);
      $display("mismatch on %s: expected %h, got %h", what, want, got);
      errors++;
   endtask

   task automatic send_point(point_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_image_x <= p.ix;
      req_image_y <= p.iy;
      req_world_x <= p.w[0];
      req_world_y <= p.w[1];
      req_world_z <= p.w[2];
      req_world_w <= p.w[3];
      req_pinv_0 <= p.p[0];
      req_pinv_1 <= p.p[1];
      req_pinv_2 <= p.p[2];
      req_pinv_3 <= p.p[3];
      req_last_point <= p.last;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      take_point(p);
   endtask

   task automatic write_focal(logic [30:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= FOCAL_ADDR;
      pwdata <= {1'b0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      focal = value;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pose_rows_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // result side: check every taken row, stall at random
   initial begin
      int           stall_left;
      pose_row_type e;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pose_rows_due.size() == 0) begin
               report_mismatch("unexpected pose row", 0, rsp_row_index);
            end else begin
               e = pose_rows_due.pop_front();
               if (rsp_row_index !== e.row) report_mismatch("row_index", e.row, rsp_row_index);
               if (rsp_col_0 !== e.c[0]) report_mismatch("col_0", e.c[0], rsp_col_0);
               if (rsp_col_1 !== e.c[1]) report_mismatch("col_1", e.c[1], rsp_col_1);
               if (rsp_col_2 !== e.c[2]) report_mismatch("col_2", e.c[2], rsp_col_2);
               if (rsp_converged !== e.conv) report_mismatch("converged", e.conv, rsp_converged);
               if (rsp_last_result !== e.last)
                  report_mismatch("last_result", e.last, rsp_last_result);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady) stall_left = pick_gap();
         end
      end
   end

   initial begin
      logic [30:0] focal_set [N_PHASES];
      int          left, run_len;
      bit          noise;
      errors = 0;
      hold_left = 0;
      steady = 0;
      npts = 0;
      focal = FOCAL_RESET;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_last_point <= 1'b0;
      {req_image_x, req_image_y, req_world_x, req_world_y, req_world_z, req_world_w} <= '0;
      {req_pinv_0, req_pinv_1, req_pinv_2, req_pinv_3} <= '0;
      rsp_ready <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= FOCAL_ADDR;
      pwdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: zero scene, field extremes, saturation, w = 0
      dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
      dir_rows.push_back(mk(ONE / 8, ONE / 8, 0, 0, 0, ONE, ONE, 0, 0, ONE / 4, 0));
      dir_rows.push_back(mk(-ONE / 8, ONE / 8, ONE, 0, 0, ONE, -ONE, 0, 0, ONE / 4, 0));
      dir_rows.push_back(mk(ONE / 8, -ONE / 8, 0, ONE, 0, ONE, 0, ONE, 0, ONE / 4, 0));
      dir_rows.push_back(mk(-ONE / 8, -ONE / 8, 0, 0, ONE, ONE, 0, -ONE, ONE, ONE / 4, 1));
      dir_rows.push_back(mk(TOP, BOT, TOP, TOP, TOP, TOP, TOP, TOP, TOP, TOP, 1));
      dir_rows.push_back(mk(BOT, TOP, BOT, BOT, BOT, BOT, BOT, BOT, BOT, BOT, 1));
      dir_rows.push_back(mk(TOP, TOP, BOT, TOP, BOT, 0, TOP, BOT, TOP, BOT, 0));
      dir_rows.push_back(mk(-1, 1, 1, -1, ONE, 0, BOT, TOP, BOT, TOP, 1));
      dir_rows.push_back(mk(ONE, 0, ONE, ONE, ONE, ONE, 0, 0, 0, 0, 1));
      foreach (dir_rows[i]) send_point(dir_rows[i]);
      drain();

      focal_set = '{31'd0, 31'h7fff_ffff, 31'h100, 31'(ONE), 31'($urandom_range(1, 31'hfff))};
      for (int ph = 0; ph < N_PHASES; ph++) begin
         write_focal(focal_set[ph]);
         steady = (ph == 2);
         // long enough to outlast the first solve of the phase
         if (ph == 1) hold_left = 40000;
         // more than MAX_POINTS points: the overflow is dropped, its last flag still counts
         if (ph == 0)
            for (int i = 0; i < MAX_POINTS + 2; i++)
               send_point(rand_point(i % 7 == 3, i == MAX_POINTS + 1));
         left = 30;
         while (left > 0) begin
            // long runs only where the convergence test passes early
            run_len = (focal_set[ph] > 31'(ONE / 2)) ? $urandom_range(1, 3)
                                                      : $urandom_range(1, 6);
            noise = ($urandom_range(0, 9) < 2);
            for (int i = 0; i < run_len; i++)
               send_point(rand_point(noise || $urandom_range(0, 15) == 0, i == run_len - 1));
            left -= run_len;
         end
         drain();
      end
      steady = 0;

      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #300_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/ipfp_pkg.sv
sv/ipfp_ram.sv
sv/ipfp_sqrt.sv
sv/ipfp_div.sv
sv/iterative_pose_from_points_top.sv
bench/tb_top.sv
